[src/gmp_pkg.sv]
`default_nettype none
package gmp_pkg;

    // grid size limits
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // index widths, kept at one bit or more for a single-column or single-row limit
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // fixed field widths
    localparam int CNT_W   = 11;
    localparam int VALUE_W = 16;
    localparam int SCORE_W = 32;
    localparam int CFG_IDX_W = 1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 1'b0,
        CFG_COL_COUNT = 1'b1
    } t_cfg_idx;

    // where the current cell sits in the grid
    typedef struct packed {
        logic first_row;
        logic first_col;
    } t_pos;

    // effective column count minus one: zero acts as one, above the limit acts as the limit
    function automatic logic [COL_W-1:0] cols_m1(input logic [CNT_W-1:0] raw);
        logic [COL_W-1:0] res;
        if (raw == '0) begin
            res = '0;
        end else if (int'(raw) > MAX_COLS) begin
            res = COL_W'(MAX_COLS - 1);
        end else begin
            res = COL_W'(raw - CNT_W'(1));
        end
        return res;
    endfunction

    // effective row count minus one
    function automatic logic [ROW_W-1:0] rows_m1(input logic [CNT_W-1:0] raw);
        logic [ROW_W-1:0] res;
        if (raw == '0) begin
            res = '0;
        end else if (int'(raw) > MAX_ROWS) begin
            res = ROW_W'(MAX_ROWS - 1);
        end else begin
            res = ROW_W'(raw - CNT_W'(1));
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[src/gmp_cell.sv]
`default_nettype none
module gmp_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_shift,
    input  wire logic                         i_load,
    input  wire logic [gmp_pkg::SCORE_W-1:0]  i_new,
    input  wire logic [gmp_pkg::SCORE_W-1:0]  i_prev,
    output logic      [gmp_pkg::SCORE_W-1:0]  o_q
);
    import gmp_pkg::*;

    logic [SCORE_W-1:0] r_q;

    // take the fresh score at the insertion point, else the neighbor's
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_load ? i_new : i_prev;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

[src/gmp_row_line.sv]
`default_nettype none
module gmp_row_line (
    input  wire logic                         i_clk,
    input  wire logic                         i_shift,
    input  wire logic [gmp_pkg::COL_W-1:0]    i_cols_m1,
    input  wire logic [gmp_pkg::SCORE_W-1:0]  i_new,
    output logic      [gmp_pkg::SCORE_W-1:0]  o_above
);
    import gmp_pkg::*;

    logic [SCORE_W-1:0] w_q [MAX_COLS];

    // delay line of row scores; a score enters cols cells before the end,
    // so it leaves exactly one row later
    for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
        logic [SCORE_W-1:0] w_prev;
        logic               w_load;

        if (k == 0) begin : g_head
            assign w_prev = i_new;
        end else begin : g_body
            assign w_prev = w_q[k-1];
        end

        assign w_load = (i_cols_m1 == COL_W'(MAX_COLS - 1 - k));

        gmp_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_load  (w_load),
            .i_new   (i_new),
            .i_prev  (w_prev),
            .o_q     (w_q[k])
        );
    end

    assign o_above = w_q[MAX_COLS-1];

endmodule
`default_nettype wire

[src/gmp_step.sv]
`default_nettype none
module gmp_step (
    input  wire logic signed [gmp_pkg::VALUE_W-1:0] i_value,
    input  wire logic        [gmp_pkg::SCORE_W-1:0] i_above,
    input  wire logic        [gmp_pkg::SCORE_W-1:0] i_left,
    input  wire logic        [gmp_pkg::SCORE_W-1:0] i_diag,
    input  wire gmp_pkg::t_pos                      i_pos,
    output logic             [gmp_pkg::SCORE_W-1:0] o_score
);
    import gmp_pkg::*;

    logic signed [SCORE_W-1:0] w_v;
    logic signed [SCORE_W-1:0] w_from_up;
    logic signed [SCORE_W-1:0] w_from_left;
    logic signed [SCORE_W-1:0] w_from_diag;
    logic signed [SCORE_W-1:0] w_best_ul;
    logic signed [SCORE_W-1:0] w_best;

    // candidate scores, all wrapping at 32 bits
    assign w_v         = SCORE_W'(i_value);
    assign w_from_up   = $signed(i_above) + w_v;
    assign w_from_left = $signed(i_left) + w_v;
    assign w_from_diag = $signed(i_diag) + (w_v <<< 1);

    // signed three-way maximum
    assign w_best_ul = (w_from_up >= w_from_left) ? w_from_up : w_from_left;
    assign w_best    = (w_best_ul >= w_from_diag) ? w_best_ul : w_from_diag;

    // edges of the grid are plain running sums
    always_comb begin
        case ({i_pos.first_row, i_pos.first_col})
            2'b11:   o_score = w_v;
            2'b10:   o_score = w_from_left;
            2'b01:   o_score = w_from_up;
            default: o_score = w_best;
        endcase
    end

endmodule
`default_nettype wire

[src/grid_max_path_dp.sv]
// Channel  | Direction | Handshake          | Payload
// -------- | --------- | ------------------ | --------------------------
// cell in  | input     | i_valid / o_stall  | i_cell_value  (16b signed)
// score out| output    | o_valid / i_stall  | o_best_score  (32b signed)
// config   | input     | i_cfg_we           | i_cfg_index, i_cfg_data (11b)
//
// One cell word is taken every cycle while o_stall is low; each cell's score is done in its cycle.
// The row store is a chain of MAX_COLS cells that shifts once per accepted word;
// a score enters cols cells before the end, so the tail always holds the score above.
// The result word is registered: o_valid is high in the cycle after the last cell.
// A skid register behind the output lets input continue under one output stall;
// o_stall rises only when both are full. Reset is synchronous, active low;
// the row chain itself is not reset and needs no clearing pass.
`default_nettype none
module grid_max_path_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [gmp_pkg::VALUE_W-1:0]  i_cell_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed      [gmp_pkg::SCORE_W-1:0]  o_best_score,
    input  wire logic                                i_cfg_we,
    input  wire logic        [gmp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [gmp_pkg::CNT_W-1:0]    i_cfg_data
);
    import gmp_pkg::*;

    logic [ROW_W-1:0]   r_rows_m1;
    logic [COL_W-1:0]   r_cols_m1;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [SCORE_W-1:0] r_left;
    logic [SCORE_W-1:0] r_diag;
    logic               r_out_valid;
    logic [SCORE_W-1:0] r_out;
    logic               r_skid_valid;
    logic [SCORE_W-1:0] r_skid;

    logic               w_acc;
    logic               w_pop;
    logic               w_last_col;
    logic               w_last_row;
    logic               w_push;
    logic [SCORE_W-1:0] w_above;
    logic [SCORE_W-1:0] w_score;
    t_pos               w_pos;

    assign w_acc      = i_valid && !o_stall;
    assign w_pop      = r_out_valid && !i_stall;
    assign w_last_col = (r_col == r_cols_m1);
    assign w_last_row = (r_row == r_rows_m1);
    assign w_push     = w_acc && w_last_col && w_last_row;

    assign w_pos.first_row = (r_row == '0);
    assign w_pos.first_col = (r_col == '0);

    // row store chain
    gmp_row_line u_line (
        .i_clk     (i_clk),
        .i_shift   (w_acc),
        .i_cols_m1 (r_cols_m1),
        .i_new     (w_score),
        .o_above   (w_above)
    );

    // score of the current cell
    gmp_step u_step (
        .i_value (i_cell_value),
        .i_above (w_above),
        .i_left  (r_left),
        .i_diag  (r_diag),
        .i_pos   (w_pos),
        .o_score (w_score)
    );

    // shape registers and grid position; any register write restarts the grid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m1 <= '0;
            r_cols_m1 <= '0;
            r_row     <= '0;
            r_col     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW_COUNT: r_rows_m1 <= rows_m1(i_cfg_data);
                CFG_COL_COUNT: r_cols_m1 <= cols_m1(i_cfg_data);
                default:       r_rows_m1 <= r_rows_m1;
            endcase
            r_row <= '0;
            r_col <= '0;
        end else if (w_acc) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // left and upper-left scores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_diag <= '0;
        end else if (w_acc) begin
            r_left <= w_score;
            r_diag <= w_above;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid <= w_score;
            end else begin
                r_out <= w_score;
            end
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_best_score = $signed(r_out);

    // skid holds a word only behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // the last cell of a grid always yields a word next cycle
    a_last_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_valid)
        else $error("final cell produced no result word");

    // skid drain keeps the output valid
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (o_valid && !r_skid_valid))
        else $error("skid word lost on drain");

    // column position stays inside the row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_cols_m1)
        else $error("column index beyond row width");

endmodule
`default_nettype wire
